// ===== rtl/core/jhl_pkg.sv =====
// ----------------------------------------------------------------------------
// jhl_pkg
// shared types and codes for the jump history list: request and result items,
// one stored history entry and the command codes
// ----------------------------------------------------------------------------
package jhl_pkg;

    localparam int unsigned DEPTH_DEFAULT = 32;
    localparam int unsigned LINE_W        = 24;
    localparam int unsigned COL_W         = 16;

    // command codes
    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_NEXT = 2'd1;
    localparam logic [1:0] CMD_PREV = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [LINE_W-1:0] pos_line;
        logic [COL_W-1:0]  pos_column;
    } jhl_req_t;

    typedef struct packed {
        logic [LINE_W-1:0] result_line;
        logic [COL_W-1:0]  result_column;
        logic              from_history;
    } jhl_rsp_t;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
    } jhl_entry_t;

endpackage

// ===== rtl/core/jhl_cell.sv =====
// ----------------------------------------------------------------------------
// jhl_cell
// one history slot of the shift chain; takes its neighbor's entry on shift
// ----------------------------------------------------------------------------
module jhl_cell (
    input  logic               clk,
    input  logic               shift,
    input  jhl_pkg::jhl_entry_t d,
    output jhl_pkg::jhl_entry_t q
);
    import jhl_pkg::*;

    jhl_entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

// ===== rtl/core/jump_history_list.sv =====
// ----------------------------------------------------------------------------
// jump_history_list
// ordered history of (line, column) positions with a browse position and
// duplicate removal by line, built as a circular chain of entry cells
// ----------------------------------------------------------------------------
// Timing: busy is high while an item is worked on; start is taken only when
// busy is low. An add, a step forward or a step back that reads a stored
// entry runs one full rotation of the cell chain, and the result strobe
// (done) follows in the next cycle. An add that finds the history full and
// no matching line takes an extra ST_EXTRA step for dropping the oldest
// entry. A step back from the end adds first and then, unless the history
// then holds a single entry, reads in a second rotation. An item that only
// echoes its input answers in the next cycle. In a rotation the oldest entry
// leaves cell 0 each cycle and the rebuilt list enters at the tail. done is
// high for exactly one cycle and cannot be held off, so the receiver must
// take result in that cycle.
// ----------------------------------------------------------------------------
module jump_history_list #(
    parameter int unsigned DEPTH = jhl_pkg::DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  jhl_pkg::jhl_req_t request,
    output logic             done,
    output jhl_pkg::jhl_rsp_t result
);
    import jhl_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);   // count and browse width
    localparam int unsigned IW = $clog2(DEPTH);       // slot index width

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_EXTRA,
        ST_READ
    } state_t;

    // control state
    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     browse_reg, browse_next;
    logic [IW-1:0]     step_reg, step_next;
    logic [IW-1:0]     target_reg, target_next;
    logic              found_reg, found_next;
    logic              then_read_reg, then_read_next;
    logic              done_reg, done_next;

    // item payload
    logic [LINE_W-1:0] line_reg, line_next;
    logic [COL_W-1:0]  col_reg, col_next;
    jhl_rsp_t          result_reg, result_next;

    // cell chain
    jhl_entry_t        cell_q [DEPTH];
    jhl_entry_t        cell_d [DEPTH];
    jhl_entry_t        push;
    jhl_entry_t        new_entry;
    logic              shift;

    // add pass helpers
    logic [CW-1:0]     step_x;
    logic              drop_now;
    logic              found_eff;
    logic [CW-1:0]     keep_count;
    logic              add_fin;
    logic [CW-1:0]     new_count;
    logic [CW-1:0]     nc_less2;
    logic [CW-1:0]     browse_inc;
    logic [CW-1:0]     next_pos;
    logic [CW-1:0]     prev_pos;

    // ------------------------------------------------------------------
    // chain of cells: cell i takes cell i+1, the tail takes the push value
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == DEPTH - 1)
            begin : g_tail
                assign cell_d[gi] = push;
            end
            else
            begin : g_body
                assign cell_d[gi] = cell_q[gi+1];
            end

            jhl_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (cell_d[gi]),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    assign new_entry = '{line: line_reg, column: col_reg};

    // ------------------------------------------------------------------
    // add pass: the entry at index j sits in cell 0 at step j; the first one whose
    // line matches is skipped by pushing cell 1 from then on, and the new
    // position is pushed right after the kept entries
    // ------------------------------------------------------------------
    assign step_x     = CW'(step_reg);
    assign drop_now   = !found_reg && (step_x < count_reg) && (cell_q[0].line == line_reg);
    assign found_eff  = found_reg | drop_now;
    assign keep_count = found_eff ? count_reg - CW'(1) : count_reg;

    assign browse_inc = browse_reg + CW'(1);
    assign next_pos   = (browse_inc < count_reg) ? browse_inc : browse_reg;
    assign prev_pos   = browse_reg - CW'(1);
    assign nc_less2   = new_count - CW'(2);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        browse_next    = browse_reg;
        step_next      = step_reg;
        target_next    = target_reg;
        found_next     = found_reg;
        then_read_next = then_read_reg;
        done_next      = 1'b0;
        line_next      = line_reg;
        col_next       = col_reg;
        result_next    = result_reg;
        push           = cell_q[0];
        shift          = 1'b0;
        add_fin        = 1'b0;
        new_count      = count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    line_next      = request.pos_line;
                    col_next       = request.pos_column;
                    step_next      = '0;
                    found_next     = 1'b0;
                    then_read_next = 1'b0;
                    // echo unless a stored entry is read later
                    result_next    = '{result_line:   request.pos_line,
                                       result_column: request.pos_column,
                                       from_history:  1'b0};
                    unique case (request.command)
                        CMD_ADD:
                        begin
                            state_next = ST_ADD;
                        end
                        CMD_NEXT:
                        begin
                            if (browse_reg < count_reg)
                            begin
                                browse_next = next_pos;
                                target_next = next_pos[IW-1:0];
                                state_next  = ST_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        CMD_PREV:
                        begin
                            if (browse_reg >= count_reg)
                            begin
                                // at the end: add first, then step back
                                then_read_next = 1'b1;
                                state_next     = ST_ADD;
                            end
                            else if (browse_reg != '0)
                            begin
                                browse_next = prev_pos;
                                target_next = prev_pos[IW-1:0];
                                state_next  = ST_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_ADD:
            begin
                shift      = 1'b1;
                found_next = found_eff;
                step_next  = step_reg + IW'(1);
                if (step_x == keep_count)
                begin
                    push = new_entry;
                end
                else if (found_eff)
                begin
                    push = cell_q[1];
                end
                else
                begin
                    push = cell_q[0];
                end
                if (step_reg == IW'(DEPTH - 1))
                begin
                    if (!found_eff && (count_reg == CW'(DEPTH)))
                    begin
                        // full and no match: the ST_EXTRA shift drops the oldest
                        state_next = ST_EXTRA;
                    end
                    else
                    begin
                        add_fin   = 1'b1;
                        new_count = found_eff ? count_reg : count_reg + CW'(1);
                    end
                end
            end

            ST_EXTRA:
            begin
                shift     = 1'b1;
                push      = new_entry;
                add_fin   = 1'b1;
                new_count = CW'(DEPTH);
            end

            ST_READ:
            begin
                shift     = 1'b1;
                push      = cell_q[0];
                step_next = step_reg + IW'(1);
                if (step_reg == target_reg)
                begin
                    result_next = '{result_line:   cell_q[0].line,
                                    result_column: cell_q[0].column,
                                    from_history:  1'b1};
                end
                if (step_reg == IW'(DEPTH - 1))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // end of an add pass
        if (add_fin)
        begin
            count_next = new_count;
            step_next  = '0;
            if (!then_read_reg)
            begin
                browse_next = new_count;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            else if (new_count == CW'(1))
            begin
                // single entry after the add: stays at the first entry, echo
                browse_next = '0;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            else
            begin
                browse_next = nc_less2;
                target_next = nc_less2[IW-1:0];
                state_next  = ST_READ;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            browse_reg    <= '0;
            step_reg      <= '0;
            target_reg    <= '0;
            found_reg     <= 1'b0;
            then_read_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            browse_reg    <= browse_next;
            step_reg      <= step_next;
            target_reg    <= target_next;
            found_reg     <= found_next;
            then_read_reg <= then_read_next;
            done_reg      <= done_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        line_reg   <= line_next;
        col_reg    <= col_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    // the history never holds more entries than cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // browse position stays within 0 .. count
    a_browse_bound: assert property (@(posedge clk) disable iff (!rst_n)
        browse_reg <= count_reg)
        else $error("browse position past the end");

    // an accepted item either starts a pass or answers in the next cycle
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item dropped");

    // the last read step always produces a result strobe
    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && step_reg == IW'(DEPTH - 1)) |=> done)
        else $error("read pass ended without result");
`endif

endmodule

// ===== tb/sv/jhl_checker.sv =====
// ----------------------------------------------------------------------------
// jhl_checker
// watches the request and result channels of the jump history list, keeps its
// own copy of the history and browse position, predicts every jump and
// compares each result strobe with the oldest pending prediction
// ----------------------------------------------------------------------------
module jhl_checker #(
    parameter int unsigned DEPTH = jhl_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  jhl_pkg::jhl_req_t request,
    input  logic              done,
    input  jhl_pkg::jhl_rsp_t result,
    output int                errors,
    output int                pending,
    output int                checked,
    output int                hist_hits,
    output int                full_drops
);
    timeunit 1ns;
    timeprecision 1ps;

    import jhl_pkg::*;

    localparam int MAX_REPORTS = 10;

    jhl_entry_t  hist_mem [DEPTH];
    int unsigned hist_count;
    int unsigned browse_pos;
    jhl_rsp_t    jump_queue [$];

    function automatic void drop_entry(int unsigned idx);
        for (int unsigned i = idx; i + 1 < hist_count; i++)
        begin
            hist_mem[i] = hist_mem[i + 1];
        end
        hist_count--;
    endfunction

    // first entry with the same line goes, a full store loses its oldest
    function automatic void record_position(logic [LINE_W-1:0] line, logic [COL_W-1:0] col);
        bit hit = 1'b0;
        for (int unsigned i = 0; i < hist_count; i++)
        begin
            if (hist_mem[i].line == line)
            begin
                drop_entry(i);
                hit = 1'b1;
                break;
            end
        end
        if (!hit && hist_count >= DEPTH)
        begin
            drop_entry(0);
            full_drops++;
        end
        hist_mem[hist_count].line   = line;
        hist_mem[hist_count].column = col;
        hist_count++;
        browse_pos = hist_count;
    endfunction

    function automatic jhl_rsp_t predict_jump(jhl_req_t req);
        jhl_rsp_t r;
        r.result_line   = req.pos_line;
        r.result_column = req.pos_column;
        r.from_history  = 1'b0;
        case (req.command)
            CMD_ADD:
            begin
                record_position(req.pos_line, req.pos_column);
            end
            CMD_NEXT:
            begin
                if (browse_pos < hist_count)
                begin
                    if (browse_pos + 1 < hist_count)
                        browse_pos++;
                    r.result_line   = hist_mem[browse_pos].line;
                    r.result_column = hist_mem[browse_pos].column;
                    r.from_history  = 1'b1;
                end
            end
            CMD_PREV:
            begin
                if (browse_pos >= hist_count)
                begin
                    record_position(req.pos_line, req.pos_column);
                    browse_pos = hist_count - 1;
                end
                if (browse_pos != 0)
                begin
                    browse_pos--;
                    r.result_line   = hist_mem[browse_pos].line;
                    r.result_column = hist_mem[browse_pos].column;
                    r.from_history  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void log_mismatch(string what, jhl_rsp_t want, jhl_rsp_t got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display({"%0t mismatch (%s): expected line %h col %h hist %b, ",
                      "got line %h col %h hist %b"},
                     $time, what, want.result_line, want.result_column, want.from_history,
                     got.result_line, got.result_column, got.from_history);
    endfunction

    // results are compared before the same edge's item is predicted
    always @(posedge clk or negedge rst_n)
    begin
        jhl_rsp_t want;
        if (!rst_n)
        begin
            hist_count = 0;
            browse_pos = 0;
            jump_queue.delete();
            errors     = 0;
            checked    = 0;
            hist_hits  = 0;
            full_drops = 0;
        end
        else
        begin
            if (done)
            begin
                if (jump_queue.size() == 0)
                begin
                    log_mismatch("result with nothing pending", '0, result);
                end
                else
                begin
                    want = jump_queue.pop_front();
                    checked++;
                    if (want.from_history)
                        hist_hits++;
                    if (result.result_line !== want.result_line
                        || result.result_column !== want.result_column
                        || result.from_history !== want.from_history)
                        log_mismatch("field", want, result);
                end
            end
            if (start && !busy)
                jump_queue = {jump_queue, predict_jump(request)};
        end
        pending = jump_queue.size();
    end

endmodule

// ===== tb/sv/tb_jump_history_list.sv =====
// ----------------------------------------------------------------------------
// tb_jump_history_list
// drives add, step forward, step back and the unused command code into the
// jump history list: a directed opening over the corner cases, then bursts
// that fill the store, browse deep into it and mix everything; the checker
// beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_jump_history_list;
    timeunit 1ns;
    timeprecision 1ps;

    import jhl_pkg::*;

    localparam int unsigned   DEPTH          = DEPTH_DEFAULT;
    localparam int            RANDOM_ITEMS   = 1330;
    localparam int            POOL_SIZE      = 48;
    localparam int            WATCHDOG_LIMIT = 4000;
    // covers a step back from the end with its drop step, with margin
    localparam int            TAIL_CYCLES    = 2 * DEPTH + 10;
    localparam int            MAX_GAP        = 40;
    localparam logic [1:0]    CMD_UNUSED     = 2'd3;
    localparam logic [LINE_W-1:0] LINE_MAX   = {LINE_W{1'b1}};
    localparam logic [COL_W-1:0]  COL_MAX    = {COL_W{1'b1}};

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    jhl_req_t request = '0;
    logic     busy;
    logic     done;
    jhl_rsp_t result;

    int errors;
    int pending;
    int checked;
    int hist_hits;
    int full_drops;

    int sent_by_cmd [4];
    int idle_pct;
    int quiet_cycles;

    logic [LINE_W-1:0] line_pool [POOL_SIZE];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    jump_history_list #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    jhl_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked),
        .hist_hits  (hist_hits),
        .full_drops (full_drops)
    );

    // watchdog: any cycle with an accepted item or a result strobe resets it
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item or result for %0d cycles, %0d results pending",
                     quiet_cycles, pending);
            $display("[jump_history_list] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // optional idle gap, then hold start until the block takes the item;
    // start is only lowered when a gap comes, so back-to-back items keep it high
    task automatic send_item(logic [1:0] cmd, logic [LINE_W-1:0] line, logic [COL_W-1:0] col);
        int gap = 0;
        while ($urandom_range(99) < idle_pct && gap < MAX_GAP)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= '{command: cmd, pos_line: line, pos_column: col};
        // busy read right after the edge is its value at that edge
        do
            @(posedge clk);
        while (busy);
        sent_by_cmd[cmd]++;
    endtask

    // lines mostly come from a small pool so that duplicates and moves happen
    function automatic logic [LINE_W-1:0] pick_line();
        int unsigned roll = $urandom_range(99);
        if (roll < 4)
            return '0;
        if (roll < 8)
            return LINE_MAX;
        if (roll < 70)
            return line_pool[$urandom_range(POOL_SIZE - 1)];
        return LINE_W'($urandom);
    endfunction

    function automatic logic [COL_W-1:0] pick_column();
        int unsigned roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return COL_MAX;
        return COL_W'($urandom);
    endfunction

    initial
    begin
        int                burst_kind;
        int                burst_len;
        int                rand_sent;
        int unsigned       roll;
        logic [1:0]        cmd;
        logic [LINE_W-1:0] line;

        foreach (sent_by_cmd[i])
            sent_by_cmd[i] = 0;
        foreach (line_pool[i])
            line_pool[i] = LINE_W'($urandom);
        line_pool[0] = '0;
        line_pool[1] = LINE_MAX;
        idle_pct = 14;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed opening ----
        // empty history: step forward echoes, step back adds and echoes
        send_item(CMD_NEXT,   '0,       '0);
        send_item(CMD_PREV,   LINE_MAX, COL_MAX);
        send_item(CMD_UNUSED, LINE_MAX, COL_MAX);
        // single entry, browse on it: step forward returns it and stays
        send_item(CMD_NEXT,   24'h000001, 16'h0001);
        send_item(CMD_NEXT,   24'h000002, 16'h0002);
        // adds echo; the last one matches an older line and moves it
        send_item(CMD_ADD,    '0,         COL_MAX);
        send_item(CMD_ADD,    24'h000005, 16'h0007);
        send_item(CMD_ADD,    24'hA5A5A5, 16'h5A5A);
        send_item(CMD_ADD,    LINE_MAX,   '0);
        // step back from the end adds first, then walks back to the oldest
        send_item(CMD_PREV,   24'h000064, 16'h0010);
        send_item(CMD_PREV,   24'h123456, 16'h1234);
        send_item(CMD_PREV,   24'h123456, 16'h1234);
        send_item(CMD_PREV,   24'h123456, 16'h1234);
        // at the first entry step back echoes and stays
        send_item(CMD_PREV,   24'h654321, 16'h4321);
        send_item(CMD_PREV,   24'h5A5A5A, 16'hA5A5);
        // forward to the newest and past it: stays on the newest
        send_item(CMD_NEXT,   24'h000000, 16'h0000);
        send_item(CMD_NEXT,   24'h000000, 16'h0000);
        send_item(CMD_NEXT,   24'h000000, 16'h0000);
        send_item(CMD_NEXT,   LINE_MAX,   COL_MAX);
        send_item(CMD_NEXT,   LINE_MAX,   COL_MAX);
        // back at the end after an add: step forward echoes
        send_item(CMD_ADD,    24'h000005, COL_MAX);
        send_item(CMD_NEXT,   24'hFEDCBA, 16'hBEEF);
        send_item(CMD_UNUSED, '0,         '0);

        // ---- random bursts ----
        // fill bursts push the store past full, browse bursts walk deep into
        // it, mixed bursts throw in everything including the unused code
        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            burst_kind = $urandom_range(9);
            burst_len  = $urandom_range(36, 8);
            for (int k = 0; k < burst_len && rand_sent < RANDOM_ITEMS; k++)
            begin
                // sender idle phases: light, then heavy, then none
                if (rand_sent < RANDOM_ITEMS / 3)
                    idle_pct = 14;
                else if (rand_sent < 2 * RANDOM_ITEMS / 3)
                    idle_pct = 45;
                else
                    idle_pct = 0;

                roll = $urandom_range(99);
                line = pick_line();
                if (burst_kind < 3)
                begin
                    cmd = (roll < 90) ? CMD_ADD : CMD_PREV;
                    if ($urandom_range(99) < 70)
                        line = LINE_W'($urandom);
                end
                else if (burst_kind < 7)
                begin
                    if (roll < 45)
                        cmd = CMD_PREV;
                    else if (roll < 85)
                        cmd = CMD_NEXT;
                    else if (roll < 95)
                        cmd = CMD_ADD;
                    else
                        cmd = CMD_UNUSED;
                end
                else
                begin
                    cmd = 2'($urandom_range(3));
                end
                send_item(cmd, line, pick_column());
                rand_sent++;
            end
        end

        // ---- drain ----
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("drove %0d items: %0d add, %0d step forward, %0d step back, %0d unused code",
                 sent_by_cmd[0] + sent_by_cmd[1] + sent_by_cmd[2] + sent_by_cmd[3],
                 sent_by_cmd[CMD_ADD], sent_by_cmd[CMD_NEXT], sent_by_cmd[CMD_PREV],
                 sent_by_cmd[CMD_UNUSED]);
        $display("checked %0d results, %0d taken from history, %0d oldest-entry drops, %0d errors",
                 checked, hist_hits, full_drops, errors);
        if (errors == 0 && pending == 0)
            $display("[jump_history_list] OK");
        else
            $display("[jump_history_list] ERROR");
        $finish;
    end

endmodule
